[rtl/core/text_console_scrollback_core_defines.svh]
// Assertion macros shared by the checker of the console core
`ifndef TEXT_CONSOLE_SCROLLBACK_CORE_DEFINES_SVH
`define TEXT_CONSOLE_SCROLLBACK_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define TCS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define TCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/tcs_pkg.sv]
// Types, constants and helper functions of the text console scrollback core
package tcs_pkg;

    localparam int RING_LINES  = 32;
    localparam int LINE_CELLS  = 128;
    localparam int RING_W      = $clog2(RING_LINES);
    localparam int TOTAL_W     = $clog2(RING_LINES + 1);
    localparam int SUM_W       = TOTAL_W + 1;
    localparam int CMP_W       = ((TOTAL_W > 8) ? TOTAL_W : 8) + 1;
    localparam int STORE_CELLS = RING_LINES * LINE_CELLS;
    localparam int ADDR_W      = $clog2(STORE_CELLS);
    localparam int COL_CAP     = (LINE_CELLS < 128) ? LINE_CELLS : 128;
    localparam int QUEUE_DEPTH = 2;
    localparam int PADDR_W     = 3;

    // register map, by paddr[2]
    localparam logic REG_COLUMN_LIMIT = 1'b0;
    localparam logic REG_ROW_LIMIT    = 1'b1;

    localparam logic [7:0] COLUMN_LIMIT_RESET = 8'd80;
    localparam logic [7:0] ROW_LIMIT_RESET    = 8'd25;

    // command opcodes
    localparam logic [2:0] OP_PUT_CHAR    = 3'd0;
    localparam logic [2:0] OP_VIEW_UP     = 3'd1;
    localparam logic [2:0] OP_VIEW_DOWN   = 3'd2;
    localparam logic [2:0] OP_VIEW_BOTTOM = 3'd3;
    localparam logic [2:0] OP_CLEAR       = 3'd4;
    localparam logic [2:0] OP_READ_CELL   = 3'd5;

    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // classified command kinds
    localparam logic [3:0] KIND_NOP         = 4'd0;
    localparam logic [3:0] KIND_GLYPH       = 4'd1;
    localparam logic [3:0] KIND_BACKSPACE   = 4'd2;
    localparam logic [3:0] KIND_NEWLINE     = 4'd3;
    localparam logic [3:0] KIND_RETURN      = 4'd4;
    localparam logic [3:0] KIND_VIEW_UP     = 4'd5;
    localparam logic [3:0] KIND_VIEW_DOWN   = 4'd6;
    localparam logic [3:0] KIND_VIEW_BOTTOM = 4'd7;
    localparam logic [3:0] KIND_CLEAR       = 4'd8;
    localparam logic [3:0] KIND_READ        = 4'd9;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] ch;
        logic [4:0] line;
        logic [6:0] col;
    } cmd_t;

    typedef struct packed {
        logic       draw_valid;
        logic [7:0] draw_row;
        logic [6:0] draw_column;
        logic [7:0] draw_code;
        logic       scroll_screen;
        logic       clear_screen;
        logic       redraw_valid;
        logic [4:0] first_line;
        logic [5:0] shown_lines;
        logic       at_bottom;
        logic [5:0] lines_held;
    } res_t;

    function automatic logic [7:0] rows_in_use(input logic [7:0] lim);
        return (lim == 8'd0) ? 8'd1 : lim;
    endfunction

    function automatic logic [7:0] cols_in_use(input logic [7:0] lim);
        logic [7:0] c;
        c = (lim == 8'd0) ? 8'd1 : lim;
        if (c > 8'(COL_CAP))
            c = 8'(COL_CAP);
        return c;
    endfunction

    // sum below twice the ring size folded back into the ring
    function automatic logic [RING_W-1:0] ring_wrap(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] t;
        t = (s >= SUM_W'(RING_LINES)) ? s - SUM_W'(RING_LINES) : s;
        return t[RING_W-1:0];
    endfunction

endpackage

[rtl/core/tcs_if.sv]
// Command and event channel interfaces of the console core
interface tcs_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [7:0] char_code;
    logic [4:0] line_index;
    logic [6:0] column_index;

    modport source (output valid, opcode, char_code, line_index, column_index,
                    input ready);
    modport sink   (input valid, opcode, char_code, line_index, column_index,
                    output ready);
endinterface

interface tcs_evt_if;
    logic       valid;
    logic       ready;
    logic       draw_valid;
    logic [7:0] draw_row;
    logic [6:0] draw_column;
    logic [7:0] draw_code;
    logic       scroll_screen;
    logic       clear_screen;
    logic       redraw_valid;
    logic [4:0] first_line;
    logic [5:0] shown_lines;
    logic [7:0] cell_char;
    logic       at_bottom;
    logic [5:0] lines_held;

    modport source (output valid, draw_valid, draw_row, draw_column, draw_code,
                    scroll_screen, clear_screen, redraw_valid, first_line,
                    shown_lines, cell_char, at_bottom, lines_held,
                    input ready);
    modport sink   (input valid, draw_valid, draw_row, draw_column, draw_code,
                    scroll_screen, clear_screen, redraw_valid, first_line,
                    shown_lines, cell_char, at_bottom, lines_held,
                    output ready);
endinterface

[rtl/core/tcs_front.sv]
// Front end: takes command transactions and classifies them for the queue
module tcs_front
    import tcs_pkg::*;
(
    tcs_cmd_if.sink cmd,
    output logic    push_valid,
    input  logic    push_ready,
    output cmd_t    push_cmd
);

    logic [3:0] kind;

    always_comb
    begin
        kind = KIND_NOP;
        case (cmd.opcode)
            OP_PUT_CHAR:
            begin
                case (cmd.char_code)
                    CH_BACKSPACE: kind = KIND_BACKSPACE;
                    CH_NEWLINE:   kind = KIND_NEWLINE;
                    CH_RETURN:    kind = KIND_RETURN;
                    default:      kind = KIND_GLYPH;
                endcase
            end
            OP_VIEW_UP:     kind = KIND_VIEW_UP;
            OP_VIEW_DOWN:   kind = KIND_VIEW_DOWN;
            OP_VIEW_BOTTOM: kind = KIND_VIEW_BOTTOM;
            OP_CLEAR:       kind = KIND_CLEAR;
            OP_READ_CELL:   kind = KIND_READ;
            default:        kind = KIND_NOP;
        endcase
    end

    assign push_cmd.kind = kind;
    assign push_cmd.ch   = cmd.char_code;
    assign push_cmd.line = cmd.line_index;
    assign push_cmd.col  = cmd.column_index;
    assign push_valid    = cmd.valid;
    assign cmd.ready     = push_ready;

endmodule

[rtl/core/tcs_queue.sv]
// Short command queue between the front and back ends
module tcs_queue
    import tcs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop,
    output cmd_t pop_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

[rtl/core/tcs_back.sv]
// Back end: cursor, line ring, line store and event output register
module tcs_back
    import tcs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] column_limit,
    input  logic [7:0] row_limit,
    input  logic       pop_valid,
    output logic       pop,
    input  cmd_t       pop_cmd,
    tcs_evt_if.source  evt
);

    // architectural state
    logic [RING_W-1:0]  head_reg, head_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [TOTAL_W-1:0] voff_reg, voff_next;
    logic [7:0]         row_reg, row_next;
    logic [6:0]         col_reg, col_next;
    logic [7:0]         fill_reg [RING_LINES];

    // line store, contents undefined until written
    logic [7:0]         text_mem [STORE_CELLS];
    logic [7:0]         rdata_reg;

    // result stage and output register
    logic               busy_reg;
    res_t               stage_res_reg;
    logic               stage_hit_reg;
    logic               out_valid_reg;
    res_t               out_res_reg;
    logic [7:0]         out_cell_reg;
    logic               retire;

    logic [7:0]         rows;
    logic [7:0]         cols;
    logic               at_bot;
    logic [RING_W-1:0]  last_line;
    logic [RING_W-1:0]  new_line;
    logic [RING_W-1:0]  head_inc;
    logic [RING_W-1:0]  read_phys;
    logic               read_in;
    logic [RING_W-1:0]  fill_addr;
    logic [7:0]         fill_rd;
    logic [7:0]         scr_row;
    logic [7:0]         col_ext;
    logic [7:0]         col_inc;
    logic [6:0]         col_dec;
    logic [7:0]         row_inc;
    logic               nl_scroll;
    logic [7:0]         nl_row;
    logic               total_full;
    logic [ADDR_W-1:0]  line_base;

    logic               do_nl;
    logic               win_en;
    logic [CMP_W-1:0]   win_t;
    logic [CMP_W-1:0]   win_r;
    logic [CMP_W-1:0]   win_v;
    logic [CMP_W-1:0]   win_shown;
    logic [CMP_W-1:0]   win_first;

    res_t               res;
    logic               hit;
    logic               fill_clear;
    logic               fill_set_en;
    logic [7:0]         fill_set_val;
    logic               fill_zero_en;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [7:0]         mem_wdata;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;

    assign retire = busy_reg && (!out_valid_reg || evt.ready);
    assign pop    = pop_valid && (!busy_reg || retire);

    assign rows       = rows_in_use(row_limit);
    assign cols       = cols_in_use(column_limit);
    assign at_bot     = (voff_reg == '0);
    assign last_line  = ring_wrap(SUM_W'(head_reg) + SUM_W'(total_reg) - SUM_W'(1));
    assign new_line   = ring_wrap(SUM_W'(head_reg) + SUM_W'(total_reg));
    assign head_inc   = ring_wrap(SUM_W'(head_reg) + SUM_W'(1));
    assign read_phys  = ring_wrap(SUM_W'(head_reg) + SUM_W'(pop_cmd.line));
    assign read_in    = CMP_W'(pop_cmd.line) < CMP_W'(total_reg);
    assign fill_addr  = (pop_cmd.kind == KIND_READ) ? read_phys : last_line;
    assign fill_rd    = fill_reg[fill_addr];
    assign scr_row    = (row_reg < rows) ? row_reg : rows - 8'd1;
    assign col_ext    = {1'b0, col_reg};
    assign col_inc    = col_ext + 8'd1;
    assign col_dec    = col_reg - 7'd1;
    assign row_inc    = (row_reg < rows) ? row_reg + 8'd1 : row_reg;
    assign nl_scroll  = (row_inc >= rows) && at_bot;
    assign nl_row     = nl_scroll ? rows - 8'd1 : row_inc;
    assign total_full = CMP_W'(total_reg) >= CMP_W'(RING_LINES);
    assign line_base  = ADDR_W'(last_line) * ADDR_W'(LINE_CELLS);
    assign mem_raddr  = ADDR_W'(read_phys) * ADDR_W'(LINE_CELLS) + ADDR_W'(pop_cmd.col);

    always_comb
    begin
        head_next    = head_reg;
        total_next   = total_reg;
        voff_next    = voff_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        res          = '0;
        hit          = 1'b0;
        do_nl        = 1'b0;
        win_en       = 1'b0;
        fill_clear   = 1'b0;
        fill_set_en  = 1'b0;
        fill_set_val = col_inc;
        fill_zero_en = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = line_base + ADDR_W'(col_reg);
        mem_wdata    = pop_cmd.ch;
        mem_re       = 1'b0;

        case (pop_cmd.kind)
            KIND_GLYPH:
            begin
                if (col_ext < cols)
                begin
                    mem_we = 1'b1;
                    if (fill_rd < col_inc)
                        fill_set_en = 1'b1;
                end
                if (at_bot)
                begin
                    res.draw_valid  = 1'b1;
                    res.draw_row    = scr_row;
                    res.draw_column = col_reg;
                    res.draw_code   = pop_cmd.ch;
                end
                if (col_inc >= cols)
                    do_nl = 1'b1;
                else
                    col_next = col_inc[6:0];
            end
            KIND_BACKSPACE:
            begin
                if (col_reg != 7'd0)
                begin
                    col_next  = col_dec;
                    mem_waddr = line_base + ADDR_W'(col_dec);
                    mem_wdata = 8'd0;
                    if (CMP_W'(col_dec) < CMP_W'(LINE_CELLS))
                        mem_we = 1'b1;
                    if (at_bot)
                    begin
                        res.draw_valid  = 1'b1;
                        res.draw_row    = scr_row;
                        res.draw_column = col_dec;
                        res.draw_code   = CH_SPACE;
                    end
                end
            end
            KIND_NEWLINE:
                do_nl = 1'b1;
            KIND_RETURN:
                col_next = 7'd0;
            KIND_VIEW_UP:
            begin
                if ((CMP_W'(total_reg) > CMP_W'(rows)) &&
                    (CMP_W'(voff_reg) < CMP_W'(total_reg) - CMP_W'(rows)))
                begin
                    voff_next = voff_reg + TOTAL_W'(1);
                    win_en    = 1'b1;
                end
            end
            KIND_VIEW_DOWN:
            begin
                if (!at_bot)
                begin
                    voff_next = voff_reg - TOTAL_W'(1);
                    win_en    = 1'b1;
                end
            end
            KIND_VIEW_BOTTOM:
            begin
                if (!at_bot)
                begin
                    voff_next = '0;
                    win_en    = 1'b1;
                end
            end
            KIND_CLEAR:
            begin
                res.clear_screen = 1'b1;
                row_next   = 8'd0;
                col_next   = 7'd0;
                voff_next  = '0;
                head_next  = '0;
                total_next = TOTAL_W'(1);
                fill_clear = 1'b1;
            end
            KIND_READ:
            begin
                mem_re = 1'b1;
                hit    = read_in && (CMP_W'(pop_cmd.col) < CMP_W'(fill_rd)) &&
                         (CMP_W'(pop_cmd.col) < CMP_W'(LINE_CELLS));
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase

        // new row: the fresh line lands one past the current last line
        if (do_nl)
        begin
            col_next          = 7'd0;
            row_next          = nl_row;
            total_next        = total_full ? total_reg : total_reg + TOTAL_W'(1);
            head_next         = total_full ? head_inc : head_reg;
            fill_zero_en      = 1'b1;
            res.scroll_screen = nl_scroll;
        end

        // redraw window; an offset past the top pins it to the newest full screen
        win_t     = CMP_W'(total_reg);
        win_r     = CMP_W'(rows);
        win_v     = CMP_W'(voff_next);
        win_shown = (win_t < win_r) ? win_t : win_r;
        win_first = '0;
        if (win_t > win_r)
            win_first = (win_v <= win_t - win_r) ? win_t - win_r - win_v : win_t - win_r;
        if (win_en)
        begin
            res.redraw_valid = 1'b1;
            res.first_line   = 5'(win_first);
            res.shown_lines  = 6'(win_shown);
        end

        res.at_bottom  = (voff_next == '0);
        res.lines_held = 6'(total_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            total_reg <= TOTAL_W'(1);
            voff_reg  <= '0;
            row_reg   <= 8'd0;
            col_reg   <= 7'd0;
            for (int i = 0; i < RING_LINES; i++)
                fill_reg[i] <= 8'd0;
        end
        else if (pop)
        begin
            head_reg  <= head_next;
            total_reg <= total_next;
            voff_reg  <= voff_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            if (fill_clear)
            begin
                for (int i = 0; i < RING_LINES; i++)
                    fill_reg[i] <= 8'd0;
            end
            else
            begin
                if (fill_set_en)
                    fill_reg[last_line] <= fill_set_val;
                if (fill_zero_en)
                    fill_reg[new_line] <= 8'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && mem_we)
            text_mem[mem_waddr] <= mem_wdata;
        if (pop && mem_re)
            rdata_reg <= text_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
                busy_reg <= 1'b1;
            else if (retire)
                busy_reg <= 1'b0;
            if (retire)
                out_valid_reg <= 1'b1;
            else if (evt.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            stage_res_reg <= res;
            stage_hit_reg <= hit;
        end
        if (retire)
        begin
            out_res_reg  <= stage_res_reg;
            out_cell_reg <= stage_hit_reg ? rdata_reg : 8'd0;
        end
    end

    assign evt.valid         = out_valid_reg;
    assign evt.draw_valid    = out_res_reg.draw_valid;
    assign evt.draw_row      = out_res_reg.draw_row;
    assign evt.draw_column   = out_res_reg.draw_column;
    assign evt.draw_code     = out_res_reg.draw_code;
    assign evt.scroll_screen = out_res_reg.scroll_screen;
    assign evt.clear_screen  = out_res_reg.clear_screen;
    assign evt.redraw_valid  = out_res_reg.redraw_valid;
    assign evt.first_line    = out_res_reg.first_line;
    assign evt.shown_lines   = out_res_reg.shown_lines;
    assign evt.cell_char     = out_cell_reg;
    assign evt.at_bottom     = out_res_reg.at_bottom;
    assign evt.lines_held    = out_res_reg.lines_held;

endmodule

[rtl/core/text_console_scrollback_core.sv]
// Text console scrollback core: top level with configuration registers
// Usage:
//   cmd  - valid/ready channel of console commands (put char, view up, view
//          down, view to bottom, clear, read cell). A transaction completes on
//          a rising edge with valid and ready high.
//   evt  - valid/ready channel with exactly one event per command: glyph draw,
//          screen scroll, clear, redraw window, cell read data, view and
//          line count status.
//   APB  - column_limit at 0x0, row_limit at 0x4; write only while idle.
// Flow: a command passes from its queue entry through the result stage register
//   to the output register; one command per cycle is sustained while evt accepts, set by the single execute
//   step that updates cursor, ring and fill marks and drives the one write or
//   read port of the 4096-cell line store.
// A two-entry command queue sits in front of the execute step, so cmd keeps
//   flowing while an event waits in the output register.
// Reset: cursor at home, one empty line, view at the bottom, limits 80 and 25.
//   No clearing pass; cells beyond a line's fill mark read as zero.
// When evt stalls, the event holds, execution stops after one more command
//   and cmd.ready drops once the queue is full.
module text_console_scrollback_core
    import tcs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    tcs_cmd_if.sink            cmd,
    tcs_evt_if.source          evt
);

    logic [7:0] column_limit_reg;
    logic [7:0] row_limit_reg;
    logic       cfg_write;
    logic       push_valid;
    logic       push_ready;
    cmd_t       push_cmd;
    logic       pop_valid;
    logic       pop;
    cmd_t       pop_cmd;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_limit_reg <= COLUMN_LIMIT_RESET;
            row_limit_reg    <= ROW_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_COLUMN_LIMIT: column_limit_reg <= pwdata[7:0];
                REG_ROW_LIMIT:    row_limit_reg    <= pwdata[7:0];
                default:          column_limit_reg <= column_limit_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_COLUMN_LIMIT: prdata = {24'd0, column_limit_reg};
            REG_ROW_LIMIT:    prdata = {24'd0, row_limit_reg};
            default:          prdata = 32'd0;
        endcase
    end

    tcs_front u_front (
        .cmd        (cmd),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    tcs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_cmd    (pop_cmd)
    );

    tcs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .column_limit (column_limit_reg),
        .row_limit    (row_limit_reg),
        .pop_valid    (pop_valid),
        .pop          (pop),
        .pop_cmd      (pop_cmd),
        .evt          (evt)
    );

endmodule

[rtl/core/tcs_checker.sv]
// Port-level checks of the console core event channel, bound to the top level
`include "text_console_scrollback_core_defines.svh"

module tcs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       draw_valid,
    input logic [7:0] draw_code,
    input logic       clear_screen,
    input logic       redraw_valid,
    input logic [5:0] shown_lines,
    input logic       at_bottom,
    input logic [5:0] lines_held
);

    // a stalled event holds
    `TCS_ASSERT_NEXT(a_evt_hold, out_valid && !out_ready, out_valid && $stable(draw_code) && $stable(lines_held) && $stable(at_bottom), "event changed while stalled")

    // glyphs are only drawn with the view at the bottom
    `TCS_ASSERT_NOW(a_draw_at_bottom, out_valid && draw_valid, at_bottom, "draw while scrolled back")

    // a clear leaves one line at the bottom and nothing else
    `TCS_ASSERT_NOW(a_clear_state, out_valid && clear_screen, at_bottom && (lines_held == 6'd1) && !draw_valid && !redraw_valid, "bad clear event")

    // a redraw window is never empty and never exceeds the stored lines
    `TCS_ASSERT_NOW(a_window_size, out_valid && redraw_valid, (shown_lines != 6'd0) && (shown_lines <= lines_held) && !at_bottom || (shown_lines != 6'd0) && (shown_lines <= lines_held), "bad redraw window")

endmodule

bind text_console_scrollback_core tcs_checker u_tcs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (evt.valid),
    .out_ready    (evt.ready),
    .draw_valid   (evt.draw_valid),
    .draw_code    (evt.draw_code),
    .clear_screen (evt.clear_screen),
    .redraw_valid (evt.redraw_valid),
    .shown_lines  (evt.shown_lines),
    .at_bottom    (evt.at_bottom),
    .lines_held   (evt.lines_held)
);
